FILE: rtl/srf_pkg.sv
`timescale 1ns / 1ps
package srf_pkg;
  localparam int unsigned OP_W = 3;
  localparam logic [OP_W-1:0] OP_WRITE  = 3'd0;
  localparam logic [OP_W-1:0] OP_READ   = 3'd1;
  localparam logic [OP_W-1:0] OP_TICK   = 3'd2;
  localparam logic [OP_W-1:0] OP_UPDATE = 3'd3;
  localparam logic [OP_W-1:0] OP_CLEAR  = 3'd4;

  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 32;
  localparam logic [CFG_IDX_W-1:0] REG_LINE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PERSISTENCE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FADE        = 2'd2;

  localparam logic [8:0] ALPHA_FULL = 9'd256;

  typedef struct packed {
    logic [2:0]  operation;
    logic [5:0]  line_index;
    logic [9:0]  column;
    logic [7:0]  red_in;
    logic [7:0]  green_in;
    logic [7:0]  blue_in;
    logic        end_of_line;
  } in_word_t;

  typedef struct packed {
    logic        found;
    logic [7:0]  red_out;
    logic [7:0]  green_out;
    logic [7:0]  blue_out;
    logic [8:0]  alpha_out;
    logic [6:0]  line_count;
  } out_word_t;

  // request to / answer from the fade divider
  typedef struct packed {
    logic        start;
    logic [43:0] dividend;
    logic [31:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [43:0] quotient;
  } div_rsp_t;
endpackage

FILE: rtl/srf_if.sv
`timescale 1ns / 1ps
interface srf_in_if;
  logic valid;
  logic ready;
  srf_pkg::in_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface srf_out_if;
  logic valid;
  logic ready;
  srf_pkg::out_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/scanline_ring_with_fade_top.sv
`timescale 1ns / 1ps
// Scan line ring with alpha fade.
// Input channel in_if carries one command word: write pixel, read pixel,
// tick, update alpha or clear. Output channel out_if returns exactly one
// result word per command: found flag, pixel, line alpha and live line count.
// Configuration (line width, persistence, fade slope) goes through a plain
// write port; the user is to write it only while the block is idle. The
// block itself does not enforce this.
// Write, tick, clear and unused codes answer from the output register after
// acceptance; a read first passes a memory read state, then the capture into
// the output register. An alpha update walks the live lines oldest first, one
// at a time: stamp read, then either a direct alpha write or a 44 step serial
// divider.
// One command is in flight at a time; the next one is taken the cycle after
// the result word is accepted.
// Reset clears the head, tail, count and time and sets the registers to their
// defaults; pixel, stamp and alpha memories are not cleared.
// When the receiver stalls, the result word holds in the output register and
// no new command is taken.
module scanline_ring_with_fade_top #(
  parameter int unsigned LINE_SLOTS = 64,
  parameter int unsigned MAX_WIDTH  = 1024
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  srf_in_if.sink                          in_if,
  srf_out_if.source                       out_if,
  input  logic                            cfg_we_i,
  input  logic [srf_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [srf_pkg::CFG_DATA_W-1:0]  cfg_data_i
);
  import srf_pkg::*;

  localparam int unsigned SW = $clog2(LINE_SLOTS);
  localparam int unsigned CW = $clog2(MAX_WIDTH);
  localparam int unsigned NW = $clog2(LINE_SLOTS + 1);
  localparam int unsigned PW = SW + CW;

  typedef enum logic [2:0] {
    ST_IDLE, ST_RD_DATA, ST_UP_READ, ST_UP_STAMP, ST_UP_DIV, ST_OUT
  } state_e;

  state_e state_q;
  logic [10:0] line_width_q;
  logic [31:0] persist_q;
  logic [11:0] fade_q;
  logic [SW-1:0] head_q, tail_q;
  logic [NW-1:0] count_q;
  logic [31:0] now_q;
  out_word_t res_q;
  logic [NW-1:0] walk_q;
  logic [SW-1:0] walk_slot_q;

  // pixel memory ports
  logic pix_we;
  logic [PW-1:0] pix_waddr, pix_raddr;
  logic [23:0] pix_rdata;
  // stamp and alpha memories
  logic st_we, al_we;
  logic [SW-1:0] st_waddr, al_waddr, st_raddr, al_raddr;
  logic [31:0] st_wdata, st_rdata;
  logic [8:0] al_wdata, al_rdata;

  div_req_t div_req;
  div_rsp_t div_rsp;

  logic in_fire, out_fire;
  logic [11:0] width_use;
  logic col_ok, idx_ok;
  logic [SW:0] age_sum;
  logic [SW-1:0] read_slot, head_next, tail_next;
  logic [NW-1:0] count_after;
  logic [43:0] drop;
  logic [8:0] fade_alpha;

  assign in_fire  = in_if.valid && in_if.ready;
  assign out_fire = out_if.valid && out_if.ready;
  assign in_if.ready  = (state_q == ST_IDLE);
  assign out_if.valid = (state_q == ST_OUT);
  assign out_if.data  = res_q;

  // clamp width to the slot size
  assign width_use = ({1'b0, line_width_q} < 13'(MAX_WIDTH)) ?
                     12'(line_width_q) : 12'(MAX_WIDTH);
  assign col_ok = (12'(in_if.data.column) < width_use);
  assign idx_ok = (NW'(in_if.data.line_index) < count_q) &&
                  (32'(in_if.data.line_index) < 32'(LINE_SLOTS));
  assign age_sum = {1'b0, tail_q} + (SW+1)'(in_if.data.line_index);
  assign read_slot = (age_sum >= (SW+1)'(LINE_SLOTS)) ?
                     SW'(age_sum - (SW+1)'(LINE_SLOTS)) : SW'(age_sum);
  assign head_next = (32'(head_q) == LINE_SLOTS - 1) ? '0 : head_q + SW'(1);
  assign tail_next = (32'(tail_q) == LINE_SLOTS - 1) ? '0 : tail_q + SW'(1);

  // live line count once the offered word is applied
  always_comb begin
    count_after = count_q;
    case (in_if.data.operation)
      OP_WRITE: begin
        if (in_if.data.end_of_line && (32'(count_q) < LINE_SLOTS)) begin
          count_after = count_q + NW'(1);
        end
      end
      OP_CLEAR: count_after = '0;
      default: ;
    endcase
  end

  // memory addressing
  assign pix_we    = in_fire && in_if.data.operation == OP_WRITE && col_ok;
  assign pix_waddr = {head_q, CW'(in_if.data.column)};
  assign pix_raddr = {read_slot, CW'(in_if.data.column)};
  assign st_we     = in_fire && in_if.data.operation == OP_WRITE &&
                     in_if.data.end_of_line;
  assign st_waddr  = head_q;
  assign st_wdata  = now_q;
  assign st_raddr  = walk_slot_q;
  assign al_raddr  = read_slot;
  assign drop      = div_rsp.quotient;
  assign fade_alpha = (drop >= 44'd256) ? 9'd0 : ALPHA_FULL - 9'(drop);

  always_comb begin
    al_we    = st_we;
    al_waddr = head_q;
    al_wdata = ALPHA_FULL;
    if (state_q == ST_UP_STAMP) begin
      al_waddr = walk_slot_q;
      al_we    = (persist_q == '0) || (st_rdata == now_q - persist_q) ||
                 ((now_q - st_rdata) >= persist_q) || (fade_q == '0);
      al_wdata = ((persist_q == '0) || (fade_q == '0)) &&
                 !((persist_q != '0) && ((now_q - st_rdata) >= persist_q)) ?
                 ALPHA_FULL : 9'd0;
    end else if (state_q == ST_UP_DIV) begin
      al_waddr = walk_slot_q;
      al_we    = div_rsp.done;
      al_wdata = fade_alpha;
    end
  end

  assign div_req.start    = (state_q == ST_UP_STAMP) && !al_we;
  assign div_req.dividend = 44'(now_q - st_rdata) * 44'(fade_q);
  assign div_req.divisor  = persist_q;

  srf_ram #(.Width(24), .Depth(LINE_SLOTS * MAX_WIDTH)) u_pix (
    .clk_i(clk_i), .we_i(pix_we), .waddr_i(pix_waddr),
    .wdata_i({in_if.data.red_in, in_if.data.green_in, in_if.data.blue_in}),
    .raddr_i(pix_raddr), .rdata_o(pix_rdata)
  );
  srf_ram #(.Width(32), .Depth(LINE_SLOTS)) u_stamp (
    .clk_i(clk_i), .we_i(st_we), .waddr_i(st_waddr), .wdata_i(st_wdata),
    .raddr_i(st_raddr), .rdata_o(st_rdata)
  );
  srf_ram #(.Width(9), .Depth(LINE_SLOTS)) u_alpha (
    .clk_i(clk_i), .we_i(al_we), .waddr_i(al_waddr), .wdata_i(al_wdata),
    .raddr_i(al_raddr), .rdata_o(al_rdata)
  );
  srf_div u_div (.clk_i(clk_i), .rst_ni(rst_ni), .req_i(div_req), .rsp_o(div_rsp));

  // control sequencer, ring pointers and registered result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      line_width_q <= 11'd1024;
      persist_q    <= '0;
      fade_q       <= 12'd256;
      head_q       <= '0;
      tail_q       <= '0;
      count_q      <= '0;
      now_q        <= '0;
      walk_q       <= '0;
      walk_slot_q  <= '0;
      res_q        <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_LINE_WIDTH:  line_width_q <= cfg_data_i[10:0];
          REG_PERSISTENCE: persist_q    <= cfg_data_i;
          REG_FADE:        fade_q       <= cfg_data_i[11:0];
          default: ;
        endcase
      end
      case (state_q)
        ST_IDLE: begin
          if (in_fire) begin
            res_q.found      <= (in_if.data.operation == OP_READ) && idx_ok && col_ok;
            res_q.red_out    <= '0;
            res_q.green_out  <= '0;
            res_q.blue_out   <= '0;
            res_q.alpha_out  <= '0;
            res_q.line_count <= 7'(count_after);
            count_q          <= count_after;
            case (in_if.data.operation)
              OP_WRITE: begin
                if (in_if.data.end_of_line) begin
                  head_q <= head_next;
                  if (32'(count_q) >= LINE_SLOTS) begin
                    tail_q <= tail_next;
                  end
                end
                state_q <= ST_OUT;
              end
              OP_READ: begin
                state_q <= ST_RD_DATA;
              end
              OP_TICK: begin
                now_q <= now_q + 32'd1;
                state_q <= ST_OUT;
              end
              OP_UPDATE: begin
                walk_q      <= '0;
                walk_slot_q <= tail_q;
                state_q <= (count_q == '0) ? ST_OUT : ST_UP_READ;
              end
              OP_CLEAR: begin
                head_q  <= '0;
                tail_q  <= '0;
                state_q <= ST_OUT;
              end
              default: state_q <= ST_OUT;
            endcase
          end
        end
        ST_RD_DATA: begin
          if (res_q.found) begin
            res_q.red_out   <= pix_rdata[23:16];
            res_q.green_out <= pix_rdata[15:8];
            res_q.blue_out  <= pix_rdata[7:0];
            res_q.alpha_out <= al_rdata;
          end
          state_q <= ST_OUT;
        end
        ST_UP_READ: state_q <= ST_UP_STAMP;
        ST_UP_STAMP, ST_UP_DIV: begin
          if (al_we) begin
            walk_q      <= walk_q + NW'(1);
            walk_slot_q <= (32'(walk_slot_q) == LINE_SLOTS - 1) ?
                           '0 : walk_slot_q + SW'(1);
            state_q <= (walk_q + NW'(1) >= count_q) ? ST_OUT : ST_UP_READ;
          end else begin
            state_q <= ST_UP_DIV;
          end
        end
        ST_OUT: if (out_fire) state_q <= ST_IDLE;
        default: state_q <= ST_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(count_q) <= LINE_SLOTS) else $error("count above slots");
  a_ring_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (32'(count_q) < LINE_SLOTS && count_q != '0)
    |-> (32'(head_q) == (32'(tail_q) + 32'(count_q)) % LINE_SLOTS))
    else $error("head/tail/count out of step");
  a_one_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> !in_if.ready) else $error("took second word in flight");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_if.valid && !out_if.ready) |=> $stable(res_q))
    else $error("result changed under stall");
`endif
endmodule

FILE: rtl/srf_ram.sv
`timescale 1ns / 1ps
module srf_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  // write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

FILE: rtl/srf_div.sv
`timescale 1ns / 1ps
module srf_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  srf_pkg::div_req_t req_i,
  output srf_pkg::div_rsp_t rsp_o
);
  import srf_pkg::*;

  logic [43:0] quot_q, quot_d;
  logic [31:0] div_q, div_d;
  logic [31:0] rem_q, rem_d;
  logic [5:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic [32:0] shifted;
  logic [33:0] trial;

  // restoring division, one quotient bit per cycle
  always_comb begin
    quot_d  = quot_q;
    div_d   = div_q;
    rem_d   = rem_q;
    cnt_d   = cnt_q;
    busy_d  = busy_q;
    done_d  = 1'b0;
    shifted = {rem_q, quot_q[43]};
    trial   = {1'b0, shifted} - {2'b00, div_q};
    if (req_i.start) begin
      quot_d = req_i.dividend;
      div_d  = req_i.divisor;
      rem_d  = '0;
      cnt_d  = 6'd44;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (!trial[33]) begin
        rem_d  = trial[31:0];
        quot_d = {quot_q[42:0], 1'b1};
      end else begin
        rem_d  = shifted[31:0];
        quot_d = {quot_q[42:0], 1'b0};
      end
      cnt_d = cnt_q - 6'd1;
      if (cnt_q == 6'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    div_q  <= div_d;
    rem_q  <= rem_d;
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quot_q;
endmodule
